// ----- hdl/plb_pkg.sv -----
// Shared types and mode codes for the pixel layer blend unit.
package plb_pkg;

    localparam logic [1:0] MODE_MULTIPLY = 2'd0;
    localparam logic [1:0] MODE_SUBTRACT = 2'd1;
    localparam logic [1:0] MODE_SCREEN   = 2'd2;
    localparam logic [1:0] MODE_OVERLAY  = 2'd3;

    localparam logic [7:0] BYTE_MAX      = 8'd255;
    localparam logic [7:0] OVERLAY_SPLIT = 8'd127;

    typedef struct packed {
        logic [7:0] top_value;
        logic [7:0] bottom_value;
        logic       last_in;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] blended_value;
        logic       last_out;
    } out_beat_t;

endpackage

// ----- hdl/pixel_layer_blend_unit.sv -----
// Pixel layer blend unit: per-byte multiply, subtract, screen and overlay blends.
//
//  channel   ports                     handshake
//  -------   -----------------------   ---------------------------------
//  input     start, busy, in_beat      beat taken when start && !busy
//  result    done, result              beat valid for one cycle on done
//  config    cfg_wr_en, cfg_wr_data    blend_mode written when cfg_wr_en
//
// One beat enters every cycle; busy is always low.
// The accepting edge loads the input register; the beat then passes through
// the multiply stage register and the divide-by-255 output register, and done
// is high while the output register holds it.
// The receiver cannot stall, so the pipeline never holds a beat back.
// rst_n clears the valid bits and the blend mode.
module pixel_layer_blend_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  plb_pkg::in_beat_t   in_beat,
    output logic                done,
    output plb_pkg::out_beat_t  result,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_wr_data
);
    import plb_pkg::*;

    logic [1:0]  mode_reg;

    logic        s1_valid_reg;
    in_beat_t    s1_beat_reg;

    logic        s2_valid_reg;
    logic [16:0] s2_num_reg;
    logic [16:0] s2_num_next;
    logic        s2_invert_reg;
    logic        s2_invert_next;
    logic        s2_sub_sel_reg;
    logic [7:0]  s2_diff_reg;
    logic [7:0]  s2_diff_next;
    logic        s2_last_reg;

    logic        out_valid_reg;
    out_beat_t   out_beat_reg;
    out_beat_t   out_beat_next;

    logic [7:0]  op_a;
    logic [7:0]  op_b;
    logic        dbl;
    logic [15:0] product;

    logic [17:0] m_val;
    logic [17:0] q_est;
    logic [17:0] rem;
    logic [17:0] q_fix;
    logic [7:0]  rounded;

    assign busy = 1'b0;

    // Operand selection and the one multiply of the blend.
    always_comb
    begin
        op_a           = s1_beat_reg.top_value;
        op_b           = s1_beat_reg.bottom_value;
        dbl            = 1'b0;
        s2_invert_next = 1'b0;
        case (mode_reg)
            MODE_MULTIPLY:
            begin
                op_a = s1_beat_reg.top_value;
                op_b = s1_beat_reg.bottom_value;
            end
            MODE_SUBTRACT:
            begin
                op_a = s1_beat_reg.top_value;
                op_b = s1_beat_reg.bottom_value;
            end
            MODE_SCREEN:
            begin
                op_a           = BYTE_MAX - s1_beat_reg.top_value;
                op_b           = BYTE_MAX - s1_beat_reg.bottom_value;
                s2_invert_next = 1'b1;
            end
            MODE_OVERLAY:
            begin
                dbl = 1'b1;
                if (s1_beat_reg.bottom_value > OVERLAY_SPLIT)
                begin
                    op_a           = BYTE_MAX - s1_beat_reg.top_value;
                    op_b           = BYTE_MAX - s1_beat_reg.bottom_value;
                    s2_invert_next = 1'b1;
                end
            end
            default:
            begin
                op_a = s1_beat_reg.top_value;
                op_b = s1_beat_reg.bottom_value;
            end
        endcase
        product      = op_a * op_b;
        s2_num_next  = dbl ? {product, 1'b0} : {1'b0, product};
        s2_diff_next = (s1_beat_reg.bottom_value > s1_beat_reg.top_value)
                       ? (s1_beat_reg.bottom_value - s1_beat_reg.top_value) : 8'd0;
    end

    // Rounded n/255 equals floor((n + 127)/255) since no tie can occur.
    // The shift estimate is at most one low, so one compare corrects it.
    always_comb
    begin
        m_val   = {1'b0, s2_num_reg} + 18'd127;
        q_est   = (m_val + (m_val >> 8) + (m_val >> 16)) >> 8;
        rem     = m_val - ((q_est << 8) - q_est);
        q_fix   = (rem >= 18'd255) ? (q_est + 18'd1) : q_est;
        rounded = s2_invert_reg ? (BYTE_MAX - q_fix[7:0]) : q_fix[7:0];
        out_beat_next.blended_value = s2_sub_sel_reg ? s2_diff_reg : rounded;
        out_beat_next.last_out      = s2_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_MULTIPLY;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            s1_valid_reg  <= start && !busy;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            s1_beat_reg <= in_beat;
        end
        if (s1_valid_reg)
        begin
            s2_num_reg     <= s2_num_next;
            s2_invert_reg  <= s2_invert_next;
            s2_sub_sel_reg <= (mode_reg == MODE_SUBTRACT);
            s2_diff_reg    <= s2_diff_next;
            s2_last_reg    <= s1_beat_reg.last_in;
        end
        if (s2_valid_reg)
        begin
            out_beat_reg <= out_beat_next;
        end
    end

    assign done   = out_valid_reg;
    assign result = out_beat_reg;

endmodule

// ----- dv/tb_pixel_layer_blend_unit.sv -----
// Self-checking testbench for the pixel layer blend unit, with a per-beat blend predictor.
module tb_pixel_layer_blend_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import plb_pkg::*;

    // Tracks the blend mode and the queue of blended bytes still to come out.
    class blend_scoreboard;
        logic [1:0] cur_mode;
        out_beat_t  pending_bytes[$];
        int         mismatches;

        function new();
            cur_mode    = MODE_MULTIPLY;
            mismatches  = 0;
        endfunction

        // Rounds n/255 to nearest; 255 is odd, so no tie can arise.
        function int round_div255(int n);
            return (2 * n + 255) / 510;
        endfunction

        function logic [7:0] blend_byte(logic [1:0] mode, int t, int b);
            int r;
            case (mode)
                MODE_MULTIPLY: r = round_div255(t * b);
                MODE_SUBTRACT: r = (b > t) ? b - t : 0;
                MODE_SCREEN:   r = 255 - round_div255((255 - t) * (255 - b));
                default:
                begin
                    if (b <= int'(OVERLAY_SPLIT))
                        r = round_div255(2 * t * b);
                    else
                        r = 255 - round_div255(2 * (255 - t) * (255 - b));
                end
            endcase
            if (r > 255)
                r = 255;
            if (r < 0)
                r = 0;
            return r[7:0];
        endfunction

        function int outstanding();
            return pending_bytes.size();
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task note_beat(in_beat_t beat);
            out_beat_t want;
            want.blended_value = blend_byte(cur_mode, int'(beat.top_value),
                                            int'(beat.bottom_value));
            want.last_out      = beat.last_in;
            pending_bytes.push_back(want);
        endtask

        task check_beat(out_beat_t got);
            out_beat_t want;
            if (pending_bytes.size() == 0)
            begin
                report($sformatf("unexpected result value=%0d last=%0b",
                                 got.blended_value, got.last_out));
                return;
            end
            want = pending_bytes.pop_front();
            if (got.blended_value !== want.blended_value)
                report($sformatf("blended_value got %0d want %0d (mode %0d)",
                                 got.blended_value, want.blended_value, cur_mode));
            if (got.last_out !== want.last_out)
                report($sformatf("last_out got %0b want %0b", got.last_out, want.last_out));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    in_beat_t   in_beat;
    logic       done;
    out_beat_t  result;
    logic       cfg_wr_en;
    logic [1:0] cfg_wr_data;

    blend_scoreboard sb = new();
    bit              no_idle = 1'b0;

    pixel_layer_blend_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .in_beat    (in_beat),
        .done       (done),
        .result     (result),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #4 clk = ~clk;

    // Inputs are noted before results so a result in the same cycle as its input would still line up.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && start && !busy)
            sb.note_beat(in_beat);
        if (rst_n === 1'b1 && done === 1'b1)
            sb.check_beat(result);
    end

    task send_beat(logic [7:0] t, logic [7:0] b, logic last);
        if (!no_idle && $urandom_range(99) < 9)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start                <= 1'b1;
        in_beat.top_value    <= t;
        in_beat.bottom_value <= b;
        in_beat.last_in      <= last;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // Stops the sender and waits until every predicted byte has come out.
    task drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
    endtask

    task write_mode(logic [1:0] mode);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        sb.cur_mode = mode;
        cfg_wr_en   <= 1'b0;
    endtask

    function logic [7:0] pick_byte();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return BYTE_MAX;
            2:       return OVERLAY_SPLIT;
            3:       return OVERLAY_SPLIT + 8'd1;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task directed_set();
        send_beat(8'd0, 8'd0, 1'b0);
        send_beat(8'd255, 8'd255, 1'b1);
        send_beat(8'd255, 8'd0, 1'b0);
        send_beat(8'd0, 8'd255, 1'b1);
        // Both overlay branches at the split, and a subtract that underflows.
        send_beat(8'd200, 8'd127, 1'b0);
        send_beat(8'd90, 8'd128, 1'b0);
    endtask

    initial
    begin
        logic [1:0] phase_modes[8];
        phase_modes = '{MODE_SUBTRACT, MODE_OVERLAY, MODE_MULTIPLY, MODE_SCREEN,
                        MODE_OVERLAY, MODE_MULTIPLY, MODE_SUBTRACT, MODE_SCREEN};

        rst_n       <= 1'b0;
        start       <= 1'b0;
        in_beat     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset mode first, then each other mode written explicitly.
        directed_set();
        write_mode(MODE_SUBTRACT);
        directed_set();
        write_mode(MODE_SCREEN);
        directed_set();
        write_mode(MODE_OVERLAY);
        directed_set();

        for (int p = 0; p < 8; p++)
        begin
            write_mode(phase_modes[p]);
            no_idle = (p == 3);
            for (int i = 0; i < 150; i++)
            begin
                if (p == 5 && i == 75)
                    drain();
                send_beat(pick_byte(), pick_byte(), $urandom_range(15) == 0);
            end
        end
        no_idle = 1'b0;

        drain();
        repeat (10) @(posedge clk);
        if (sb.outstanding() != 0)
            sb.report($sformatf("%0d results never arrived", sb.outstanding()));
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #400us;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
